FILE: rtl/raster_to_jpeg_mcu_gather_unit_defines.svh
// ----------------------------------------------------------------------------
// MCU gather unit: assertion macros
// Shared concurrent assertion forms, clocked on the rising edge, off in reset.
// ----------------------------------------------------------------------------
`ifndef RASTER_TO_JPEG_MCU_GATHER_UNIT_DEFINES_SVH
`define RASTER_TO_JPEG_MCU_GATHER_UNIT_DEFINES_SVH

// same-cycle implication
`define RTJMG_ASSERT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RTJMG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/rtjmg_pkg.sv
// ----------------------------------------------------------------------------
// MCU gather package
// Field widths, format and register codes, and the types shared by the unit.
// ----------------------------------------------------------------------------
package rtjmg_pkg;

    localparam int FMT_W      = 4;
    localparam int DIM_W      = 13;
    localparam int ADDR_W     = 32;
    localparam int PAY_W      = 26;
    localparam int COMP_W     = 2;
    localparam int CLS_W      = 2;
    localparam int BYTE_W     = 9;
    localparam int X_W        = 15;
    localparam int STRIDE_W   = 15;
    localparam int PROD_W     = DIM_W + STRIDE_W;
    localparam int CPO_W      = 2 * DIM_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int Q_DEPTH    = 4;

    localparam logic [FMT_W-1:0] FMT_YUYV   = 4'd0;
    localparam logic [FMT_W-1:0] FMT_YVYU   = 4'd1;
    localparam logic [FMT_W-1:0] FMT_UYVY   = 4'd2;
    localparam logic [FMT_W-1:0] FMT_NV12   = 4'd3;
    localparam logic [FMT_W-1:0] FMT_NV21   = 4'd4;
    localparam logic [FMT_W-1:0] FMT_YUV444 = 4'd5;
    localparam logic [FMT_W-1:0] FMT_GRAY   = 4'd6;

    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_FORMAT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_BASE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_BASE    = 3'd4;

    localparam logic [COMP_W-1:0] COMP_Y  = 2'd0;
    localparam logic [COMP_W-1:0] COMP_CB = 2'd1;
    localparam logic [COMP_W-1:0] COMP_CR = 2'd2;

    localparam logic [CLS_W-1:0] CLS_422  = 2'd0;
    localparam logic [CLS_W-1:0] CLS_420  = 2'd1;
    localparam logic [CLS_W-1:0] CLS_444  = 2'd2;
    localparam logic [CLS_W-1:0] CLS_GRAY = 2'd3;

    typedef enum logic [1:0] {
        K_IDLE,
        K_ERR,
        K_EMPTY,
        K_BYTE
    } t_kind;

    typedef struct packed {
        logic [FMT_W-1:0]  fmt;
        logic [DIM_W-1:0]  width;
        logic [DIM_W-1:0]  height;
        logic [ADDR_W-1:0] src_base;
        logic [ADDR_W-1:0] dst_base;
    } t_cfg;

    typedef struct packed {
        logic              ok;
        logic              wide;
        logic              tall;
        logic [BYTE_W-1:0] last_byte;
        logic [CLS_W-1:0]  cls;
        logic [1:0]        stride_mul;
    } t_geom;

    // one word of work between front and back
    typedef struct packed {
        t_kind             kind;
        logic              restart;
        logic [DIM_W-1:0]  y;
        logic [X_W-1:0]    x;
        logic              plane;
        logic [COMP_W-1:0] comp;
        logic              last_mcu;
        logic              last_frame;
        logic [CLS_W-1:0]  ofmt;
    } t_entry;

    typedef struct packed {
        logic              valid_res;
        logic              error;
        logic [ADDR_W-1:0] src_addr;
        logic [ADDR_W-1:0] dst_addr;
        logic [COMP_W-1:0] component;
        logic              last_in_mcu;
        logic              last_in_frame;
        logic [PAY_W-1:0]  payload_bytes;
        logic [CLS_W-1:0]  out_format;
    } t_result;

    function automatic t_geom fmt_geom(input logic [FMT_W-1:0] f);
        t_geom g;
        g.ok         = 1'b1;
        g.wide       = 1'b0;
        g.tall       = 1'b0;
        g.last_byte  = 9'd63;
        g.cls        = CLS_GRAY;
        g.stride_mul = 2'd1;
        case (f)
            FMT_YUYV, FMT_YVYU, FMT_UYVY: begin
                g.wide       = 1'b1;
                g.last_byte  = 9'd255;
                g.cls        = CLS_422;
                g.stride_mul = 2'd2;
            end
            FMT_NV12, FMT_NV21: begin
                g.wide      = 1'b1;
                g.tall      = 1'b1;
                g.last_byte = 9'd383;
                g.cls       = CLS_420;
            end
            FMT_YUV444: begin
                g.last_byte  = 9'd191;
                g.cls        = CLS_444;
                g.stride_mul = 2'd3;
            end
            FMT_GRAY: begin
                g.cls = CLS_GRAY;
            end
            default: begin
                g.ok        = 1'b0;
                g.wide      = 1'b1;
                g.tall      = 1'b1;
                g.last_byte = 9'd0;
                g.cls       = CLS_422;
            end
        endcase
        return g;
    endfunction

endpackage

FILE: rtl/rtjmg_ifs.sv
// ----------------------------------------------------------------------------
// MCU gather channels
// Request, result and register-write channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface rtjmg_in_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface rtjmg_out_if;
    import rtjmg_pkg::*;
    logic              valid;
    logic              ready;
    logic              valid_res;
    logic              error;
    logic [ADDR_W-1:0] src_addr;
    logic [ADDR_W-1:0] dst_addr;
    logic [COMP_W-1:0] component;
    logic              last_in_mcu;
    logic              last_in_frame;
    logic [PAY_W-1:0]  payload_bytes;
    logic [CLS_W-1:0]  out_format;

    modport source (output valid, output valid_res, output error, output src_addr,
                    output dst_addr, output component, output last_in_mcu,
                    output last_in_frame, output payload_bytes, output out_format,
                    input ready);
    modport sink   (input valid, input valid_res, input error, input src_addr,
                    input dst_addr, input component, input last_in_mcu,
                    input last_in_frame, input payload_bytes, input out_format,
                    output ready);
endinterface

interface rtjmg_cfg_if;
    import rtjmg_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/rtjmg_front.sv
// ----------------------------------------------------------------------------
// MCU gather front end
// Takes request words, walks the MCU order and classifies each output byte.
// ----------------------------------------------------------------------------
`include "raster_to_jpeg_mcu_gather_unit_defines.svh"

module rtjmg_front #(
    parameter int HCNT_W = 10,
    parameter int VCNT_W = 10
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_restart,
    input  rtjmg_pkg::t_cfg    i_cfg,
    input  logic               i_full,
    output logic               o_push,
    output rtjmg_pkg::t_entry  o_entry
);
    import rtjmg_pkg::*;

    logic              r_active, n_active;
    logic [FMT_W-1:0]  r_fmt, n_fmt;
    logic [HCNT_W-1:0] r_hcnt, n_hcnt, r_col, n_col;
    logic [VCNT_W-1:0] r_vcnt, n_vcnt, r_row, n_row;
    logic [BYTE_W-1:0] r_byte, n_byte;

    t_geom             cfg_geom, cur_geom, st_geom;
    logic [DIM_W-4:0]  hsh, vsh;
    logic              accept;
    logic              c_active;
    logic [FMT_W-1:0]  c_fmt;
    logic [HCNT_W-1:0] c_hcnt, c_col;
    logic [VCNT_W-1:0] c_vcnt, c_row;
    logic [BYTE_W-1:0] c_byte;
    logic              last_mcu, last_col, last_row, last_frame;

    logic [DIM_W-1:0]  row8, row16;
    logic [X_W-1:0]    col8, col16, xp;
    logic [2:0]        r3, c3;
    logic [1:0]        off;
    logic              cb;

    assign accept  = i_valid && !i_full;
    assign o_ready = !i_full;
    assign o_push  = accept;
    assign st_geom = fmt_geom(r_fmt);

    // restart takes fresh geometry from the registers
    always_comb begin
        cfg_geom = fmt_geom(i_cfg.fmt);
        hsh = cfg_geom.wide ? {1'b0, i_cfg.width[DIM_W-1:4]} : i_cfg.width[DIM_W-1:3];
        vsh = cfg_geom.tall ? {1'b0, i_cfg.height[DIM_W-1:4]} : i_cfg.height[DIM_W-1:3];
        c_fmt    = r_fmt;
        c_hcnt   = r_hcnt;
        c_vcnt   = r_vcnt;
        c_col    = r_col;
        c_row    = r_row;
        c_byte   = r_byte;
        c_active = r_active;
        if (i_restart) begin
            c_fmt    = i_cfg.fmt;
            c_hcnt   = HCNT_W'(hsh);
            c_vcnt   = VCNT_W'(vsh);
            c_col    = '0;
            c_row    = '0;
            c_byte   = '0;
            c_active = cfg_geom.ok && (hsh != '0) && (vsh != '0);
        end
        cur_geom   = fmt_geom(c_fmt);
        last_mcu   = (c_byte == cur_geom.last_byte);
        last_col   = (c_col == c_hcnt - HCNT_W'(1));
        last_row   = (c_row == c_vcnt - VCNT_W'(1));
        last_frame = last_mcu && last_col && last_row;
    end

    // source coordinates of the current byte
    always_comb begin
        r3    = c_byte[5:3];
        c3    = c_byte[2:0];
        row8  = DIM_W'({c_row, 3'b000});
        row16 = DIM_W'({c_row, 4'b0000});
        col8  = X_W'({c_col, 3'b000});
        col16 = X_W'({c_col, 4'b0000});
        cb    = !c_byte[6];
        off   = 2'd0;
        xp    = '0;

        o_entry            = '0;
        o_entry.restart    = i_restart;
        o_entry.y          = row8 + DIM_W'(r3);
        o_entry.last_mcu   = last_mcu;
        o_entry.last_frame = last_frame;
        o_entry.ofmt       = cur_geom.cls;

        case (c_fmt)
            FMT_YUYV, FMT_YVYU, FMT_UYVY: begin
                if (c_byte[8:7] == 2'b00) begin
                    xp        = col16 + X_W'({c_byte[6], 3'b000}) + X_W'(c3);
                    o_entry.x = X_W'({xp, 1'b0}) + X_W'(c_fmt == FMT_UYVY);
                    o_entry.comp = COMP_Y;
                end else begin
                    xp = col8 + X_W'(c3);
                    case (c_fmt)
                        FMT_YUYV: off = cb ? 2'd1 : 2'd3;
                        FMT_YVYU: off = cb ? 2'd3 : 2'd1;
                        default:  off = cb ? 2'd0 : 2'd2;
                    endcase
                    o_entry.x    = X_W'({xp, 2'b00}) + X_W'(off);
                    o_entry.comp = cb ? COMP_CB : COMP_CR;
                end
            end
            FMT_NV12, FMT_NV21: begin
                if (!c_byte[8]) begin
                    o_entry.y = row16 + DIM_W'({c_byte[7], 3'b000}) + DIM_W'(r3);
                    o_entry.x = col16 + X_W'({c_byte[6], 3'b000}) + X_W'(c3);
                    o_entry.comp = COMP_Y;
                end else begin
                    // interleaved chroma plane, order swapped for NV21
                    xp = col8 + X_W'(c3);
                    o_entry.x = X_W'({xp, 1'b0}) + X_W'((c_fmt == FMT_NV12) ? !cb : cb);
                    o_entry.plane = 1'b1;
                    o_entry.comp  = cb ? COMP_CB : COMP_CR;
                end
            end
            FMT_YUV444: begin
                xp           = col8 + X_W'(c3);
                o_entry.x    = X_W'({xp, 1'b0}) + xp + X_W'(c_byte[7:6]);
                o_entry.comp = c_byte[7:6];
            end
            default: begin
                o_entry.x    = col8 + X_W'(c3);
                o_entry.comp = COMP_Y;
            end
        endcase

        if (i_restart && !cfg_geom.ok) begin
            o_entry            = '0;
            o_entry.kind       = K_ERR;
            o_entry.restart    = 1'b1;
            o_entry.last_frame = 1'b1;
        end else if (i_restart && !c_active) begin
            o_entry            = '0;
            o_entry.kind       = K_EMPTY;
            o_entry.restart    = 1'b1;
            o_entry.last_frame = 1'b1;
            o_entry.ofmt       = cfg_geom.cls;
        end else if (!c_active) begin
            o_entry      = '0;
            o_entry.kind = K_IDLE;
        end else begin
            o_entry.kind = K_BYTE;
        end
    end

    always_comb begin
        n_active = r_active;
        n_fmt    = r_fmt;
        n_hcnt   = r_hcnt;
        n_vcnt   = r_vcnt;
        n_col    = r_col;
        n_row    = r_row;
        n_byte   = r_byte;
        if (accept) begin
            n_fmt  = c_fmt;
            n_hcnt = c_hcnt;
            n_vcnt = c_vcnt;
            if (!c_active || last_frame) begin
                n_active = 1'b0;
                n_col    = '0;
                n_row    = '0;
                n_byte   = '0;
            end else if (last_mcu) begin
                n_active = 1'b1;
                n_byte   = '0;
                if (last_col) begin
                    n_col = '0;
                    n_row = c_row + VCNT_W'(1);
                end else begin
                    n_col = c_col + HCNT_W'(1);
                    n_row = c_row;
                end
            end else begin
                n_active = 1'b1;
                n_col    = c_col;
                n_row    = c_row;
                n_byte   = c_byte + BYTE_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_fmt    <= '0;
            r_hcnt   <= '0;
            r_vcnt   <= '0;
            r_col    <= '0;
            r_row    <= '0;
            r_byte   <= '0;
        end else begin
            r_active <= n_active;
            r_fmt    <= n_fmt;
            r_hcnt   <= n_hcnt;
            r_vcnt   <= n_vcnt;
            r_col    <= n_col;
            r_row    <= n_row;
            r_byte   <= n_byte;
        end
    end

    `RTJMG_ASSERT(a_active_dims, i_clk, i_rst_n, r_active, (r_hcnt != '0) && (r_vcnt != '0), "active frame with no MCUs")
    `RTJMG_ASSERT(a_pos_in_frame, i_clk, i_rst_n, r_active, (r_col < r_hcnt) && (r_row < r_vcnt), "MCU position outside frame")
    `RTJMG_ASSERT(a_byte_in_mcu, i_clk, i_rst_n, r_active, r_byte <= st_geom.last_byte, "byte index past end of MCU")
    `RTJMG_ASSERT_NEXT(a_frame_end, i_clk, i_rst_n, accept && (o_entry.kind == K_BYTE) && o_entry.last_frame, !r_active && (r_byte == '0), "walker not idle after last byte")

endmodule

FILE: rtl/rtjmg_queue.sv
// ----------------------------------------------------------------------------
// MCU gather queue
// Short first-in first-out buffer between the front and back ends.
// ----------------------------------------------------------------------------
module rtjmg_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  rtjmg_pkg::t_entry  i_entry,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_valid,
    output rtjmg_pkg::t_entry  o_entry
);
    import rtjmg_pkg::*;

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_entry           r_mem [Q_DEPTH];
    logic [PTR_W-1:0] r_wp, n_wp, r_rp, n_rp;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == CNT_W'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_entry = r_mem[r_rp];

    always_comb begin
        n_wp  = i_push ? r_wp + PTR_W'(1) : r_wp;
        n_rp  = i_pop ? r_rp + PTR_W'(1) : r_rp;
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

endmodule

FILE: rtl/rtjmg_back.sv
// ----------------------------------------------------------------------------
// MCU gather back end
// Turns classified words into byte addresses: row multiply, then final sum.
// ----------------------------------------------------------------------------
module rtjmg_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  rtjmg_pkg::t_entry  i_q_entry,
    output logic               o_pop,
    input  rtjmg_pkg::t_cfg    i_cfg,
    output logic               o_valid,
    input  logic               i_ready,
    output rtjmg_pkg::t_result o_res
);
    import rtjmg_pkg::*;

    typedef struct packed {
        t_entry            e;
        logic [PROD_W-1:0] prod;
        logic [ADDR_W-1:0] dst;
        logic [PAY_W-1:0]  pay;
    } t_stage;

    logic              adv;
    logic              r_v1, r_ov;
    t_stage            r_s1, n_s1;
    t_result           r_out, n_out;

    // per-frame state, loaded when a restart word leaves the queue
    logic [STRIDE_W-1:0] r_stride, n_stride;
    logic [CPO_W-1:0]    r_cpo;
    logic [ADDR_W-1:0]   r_src;
    logic [ADDR_W-1:0]   r_ptr, dst_cur;
    logic [PAY_W-1:0]    r_cnt, cnt_inc;
    t_geom               geom;
    logic [ADDR_W-1:0]   src_sum;

    assign adv     = !r_ov || i_ready;
    assign o_pop   = adv && i_q_valid;
    assign o_valid = r_ov;
    assign o_res   = r_out;

    always_comb begin
        geom     = fmt_geom(i_cfg.fmt);
        n_stride = STRIDE_W'(i_cfg.width);
        if (geom.stride_mul == 2'd2) begin
            n_stride = STRIDE_W'({i_cfg.width, 1'b0});
        end else if (geom.stride_mul == 2'd3) begin
            n_stride = STRIDE_W'({i_cfg.width, 1'b0}) + STRIDE_W'(i_cfg.width);
        end
        dst_cur = i_q_entry.restart ? i_cfg.dst_base : r_ptr;
        cnt_inc = (i_q_entry.restart ? PAY_W'(0) : r_cnt) + PAY_W'(1);

        // first word of a frame sits on row zero, so the old stride is harmless
        n_s1.e    = i_q_entry;
        n_s1.prod = PROD_W'(i_q_entry.y) * PROD_W'(r_stride);
        n_s1.dst  = dst_cur;
        n_s1.pay  = cnt_inc;
    end

    always_comb begin
        src_sum = r_src + ADDR_W'(r_s1.prod) + ADDR_W'(r_s1.e.x)
                + (r_s1.e.plane ? ADDR_W'(r_cpo) : ADDR_W'(0));
        n_out = '0;
        case (r_s1.e.kind)
            K_ERR: begin
                n_out.error         = 1'b1;
                n_out.last_in_frame = 1'b1;
            end
            K_EMPTY: begin
                n_out.last_in_frame = 1'b1;
                n_out.out_format    = r_s1.e.ofmt;
            end
            K_BYTE: begin
                n_out.valid_res     = 1'b1;
                n_out.src_addr      = src_sum;
                n_out.dst_addr      = r_s1.dst;
                n_out.component     = r_s1.e.comp;
                n_out.last_in_mcu   = r_s1.e.last_mcu;
                n_out.last_in_frame = r_s1.e.last_frame;
                n_out.payload_bytes = r_s1.e.last_frame ? r_s1.pay : PAY_W'(0);
                n_out.out_format    = r_s1.e.ofmt;
            end
            default: begin
                n_out = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_ov <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_q_valid;
            r_ov <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stride <= '0;
            r_cpo    <= '0;
            r_src    <= '0;
        end else if (o_pop && i_q_entry.restart) begin
            r_stride <= n_stride;
            r_cpo    <= CPO_W'(i_cfg.width) * CPO_W'(i_cfg.height);
            r_src    <= i_cfg.src_base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1  <= n_s1;
            r_out <= n_out;
        end
        if (o_pop && (i_q_entry.kind == K_BYTE)) begin
            r_ptr <= dst_cur + ADDR_W'(1);
            r_cnt <= cnt_inc;
        end
    end

endmodule

FILE: rtl/raster_to_jpeg_mcu_gather_unit.sv
// ----------------------------------------------------------------------------
// Raster to JPEG MCU gather unit
// Each request word yields one result word: restart=1 latches the registers
// and gives the first byte of a new frame (or an error or empty-frame word),
// restart=0 gives the next byte in MCU order with its source and destination
// byte addresses for a DMA. One word is taken per clock while the queue has
// room and one result leaves per clock while the output is ready; a request
// passes through the queue, the row-multiply stage and the output register.
// The rate is set by the MCU walker in the front end and the one row
// multiplier in the back end; a four-word queue between them and the output
// register let the request side keep going while a result waits. Registers
// may be written only while no result is outstanding; widths and heights
// above MAX_WIDTH and MAX_HEIGHT saturate.
// ----------------------------------------------------------------------------
module raster_to_jpeg_mcu_gather_unit #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rtjmg_in_if.sink    i_in,
    rtjmg_out_if.source o_out,
    rtjmg_cfg_if.sink   i_cfg
);
    import rtjmg_pkg::*;

    localparam int DIM_MAX = (1 << DIM_W) - 1;
    localparam int W_EFF   = (MAX_WIDTH < DIM_MAX) ? MAX_WIDTH : DIM_MAX;
    localparam int H_EFF   = (MAX_HEIGHT < DIM_MAX) ? MAX_HEIGHT : DIM_MAX;
    localparam int HCNT_W  = $clog2(W_EFF / 8 + 1);
    localparam int VCNT_W  = $clog2(H_EFF / 8 + 1);

    logic [FMT_W-1:0]  r_fmt;
    logic [DIM_W-1:0]  r_width, r_height;
    logic [ADDR_W-1:0] r_src_base, r_dst_base;

    t_cfg    cfg;
    logic    q_push, q_full, q_pop, q_valid;
    t_entry  f_entry, q_entry;
    t_result res;
    logic    front_ready;
    logic    out_valid;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt      <= '0;
            r_width    <= '0;
            r_height   <= '0;
            r_src_base <= '0;
            r_dst_base <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                CFG_PIXEL_FORMAT: r_fmt      <= i_cfg.data[FMT_W-1:0];
                CFG_FRAME_WIDTH:  r_width    <= i_cfg.data[DIM_W-1:0];
                CFG_FRAME_HEIGHT: r_height   <= i_cfg.data[DIM_W-1:0];
                CFG_SOURCE_BASE:  r_src_base <= i_cfg.data[ADDR_W-1:0];
                CFG_DEST_BASE:    r_dst_base <= i_cfg.data[ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    // saturated width, scaled by bytes per pixel in the back end, gives the raster stride
    always_comb begin
        cfg.fmt      = r_fmt;
        cfg.width    = (32'(r_width) > 32'(W_EFF)) ? DIM_W'(W_EFF) : r_width;
        cfg.height   = (32'(r_height) > 32'(H_EFF)) ? DIM_W'(H_EFF) : r_height;
        cfg.src_base = r_src_base;
        cfg.dst_base = r_dst_base;
    end

    rtjmg_front #(
        .HCNT_W (HCNT_W),
        .VCNT_W (VCNT_W)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in.valid),
        .o_ready   (front_ready),
        .i_restart (i_in.restart),
        .i_cfg     (cfg),
        .i_full    (q_full),
        .o_push    (q_push),
        .o_entry   (f_entry)
    );

    assign i_in.ready = front_ready;

    rtjmg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (f_entry),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_entry (q_entry)
    );

    rtjmg_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_entry (q_entry),
        .o_pop     (q_pop),
        .i_cfg     (cfg),
        .o_valid   (out_valid),
        .i_ready   (o_out.ready),
        .o_res     (res)
    );

    assign o_out.valid         = out_valid;
    assign o_out.valid_res     = res.valid_res;
    assign o_out.error         = res.error;
    assign o_out.src_addr      = res.src_addr;
    assign o_out.dst_addr      = res.dst_addr;
    assign o_out.component     = res.component;
    assign o_out.last_in_mcu   = res.last_in_mcu;
    assign o_out.last_in_frame = res.last_in_frame;
    assign o_out.payload_bytes = res.payload_bytes;
    assign o_out.out_format    = res.out_format;

endmodule
